// ===== design/c3rb_pkg.sv =====
// ----------------------------------------------------------------------------
// c3rb_pkg: shared types and constants for the 3x3 replicate-border convolver
// Transaction structs, register indexes, column-vector modes and the op
// control word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package c3rb_pkg;

    localparam int NUM_CH       = 4;
    localparam int SAMPLE_W     = 8;
    localparam int COEF_W       = 16;
    localparam int RESULT_W     = 28;
    localparam int GEOM_W       = 11;
    localparam int CHAN_W       = 3;
    localparam int COEF_GROUP_W = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int KSIZE        = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_LANES      = 4;

    localparam logic [GEOM_W-1:0]       RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [GEOM_W-1:0]       RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [CHAN_W-1:0]       RST_CHANNELS     = 3'd3;
    localparam logic [COEF_GROUP_W-1:0] RST_COEF_SIDE    = 48'd280379743338240;
    localparam logic [COEF_GROUP_W-1:0] RST_COEF_CENTER  = 48'd280375599365888;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_CHANNELS     = 3'd2,
        CFG_COEF_LEFT    = 3'd3,
        CFG_COEF_CENTER  = 3'd4,
        CFG_COEF_RIGHT   = 3'd5
    } cfg_index_t;

    // rows (top, middle, bottom) of one column vector
    typedef enum logic [2:0] {
        VEC_ROW0,    // cur, cur, cur
        VEC_ROW1,    // prev, prev, cur
        VEC_ROWN,    // older, prev, cur
        VEC_DRAIN1,  // prev, prev, prev
        VEC_DRAINN   // older, prev, prev
    } vec_mode_t;

    typedef struct packed {
        vec_mode_t mode;
        logic      write;
        logic      emit;
        logic      wrap;
        logic      clamp;
        logic      last;
    } op_ctl_t;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample_c0;
        logic [SAMPLE_W-1:0] sample_c1;
        logic [SAMPLE_W-1:0] sample_c2;
        logic [SAMPLE_W-1:0] sample_c3;
    } pixel_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_c0;
        logic signed [RESULT_W-1:0] result_c1;
        logic signed [RESULT_W-1:0] result_c2;
        logic signed [RESULT_W-1:0] result_c3;
        logic                       frame_last;
    } result_item_t;

endpackage

// ===== design/c3rb_fifo.sv =====
// ----------------------------------------------------------------------------
// c3rb_fifo: op queue between front end and back end
// Small register queue; each side stalls on its own.
// ----------------------------------------------------------------------------
module c3rb_fifo #(
    parameter int COL_W = 10,
    parameter int PIX_W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  c3rb_pkg::op_ctl_t   push_ctl,
    input  logic [COL_W-1:0]    push_col,
    input  logic [PIX_W-1:0]    push_pix,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output c3rb_pkg::op_ctl_t   pop_ctl,
    output logic [COL_W-1:0]    pop_col,
    output logic [PIX_W-1:0]    pop_pix
);
    import c3rb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_ctl_t          ctl_mem [QUEUE_DEPTH];
    logic [COL_W-1:0] col_mem [QUEUE_DEPTH];
    logic [PIX_W-1:0] pix_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_ctl = ctl_mem[rd_ptr_reg];
    assign pop_col = col_mem[rd_ptr_reg];
    assign pop_pix = pix_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg] <= push_ctl;
            col_mem[wr_ptr_reg] <= push_col;
            pix_mem[wr_ptr_reg] <= push_pix;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

// ===== design/c3rb_front.sv =====
// ----------------------------------------------------------------------------
// c3rb_front: input classification and raster tracking
// Tracks frame position, drops items that do nothing, and turns pixels and
// drains into column-step ops for the back end.
// ----------------------------------------------------------------------------
module c3rb_front #(
    parameter int COL_W = 10,
    parameter int ROW_W = 10,
    parameter int LANES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_stall,
    input  c3rb_pkg::pixel_item_t       pixel,
    input  logic                        restart,
    input  logic [COL_W-1:0]            w_m1,
    input  logic [ROW_W-1:0]            h_m1,
    output logic                        push,
    output c3rb_pkg::op_ctl_t           push_ctl,
    output logic [COL_W-1:0]            push_col,
    output logic [LANES*c3rb_pkg::SAMPLE_W-1:0] push_pix,
    input  logic                        full
);
    import c3rb_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             complete_reg, complete_next;
    logic [COL_W-1:0] drain_col_reg, drain_col_next;
    logic             wrapped_reg, wrapped_next;
    logic             prime_reg, prime_next;

    logic [SAMPLE_W-1:0] samples [NUM_CH];
    logic accept, is_pix, is_drain, do_prime;

    assign samples[0] = pixel.sample_c0;
    assign samples[1] = pixel.sample_c1;
    assign samples[2] = pixel.sample_c2;
    assign samples[3] = pixel.sample_c3;

    for (genvar l = 0; l < LANES; l++)
    begin : g_pix
        assign push_pix[l*SAMPLE_W +: SAMPLE_W] = samples[l];
    end

    assign pixel_stall = full || prime_reg;
    assign accept      = pixel_valid && !pixel_stall;
    assign is_pix      = accept && (pixel.action == ACT_PIXEL) && !complete_reg;
    assign is_drain    = accept && (pixel.action == ACT_DRAIN) && complete_reg;
    // single-row frames need the window loaded before the first drain
    assign do_prime    = prime_reg && !full;

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        complete_next  = complete_reg;
        drain_col_next = drain_col_reg;
        wrapped_next   = wrapped_reg;
        prime_next     = prime_reg;
        push           = 1'b0;
        push_ctl       = '0;
        push_col       = col_reg;

        if (restart)
        begin
            col_next       = '0;
            row_next       = '0;
            complete_next  = 1'b0;
            drain_col_next = '0;
            wrapped_next   = 1'b0;
            prime_next     = 1'b0;
        end
        else if (is_pix)
        begin
            push           = 1'b1;
            push_ctl.write = 1'b1;
            if (row_reg == '0)
            begin
                push_ctl.mode = VEC_ROW0;
            end
            else if (row_reg == ROW_W'(1))
            begin
                push_ctl.mode = VEC_ROW1;
            end
            else
            begin
                push_ctl.mode = VEC_ROWN;
            end
            push_ctl.emit  = (row_reg != '0) && ((col_reg != '0) || (row_reg != ROW_W'(1)));
            push_ctl.wrap  = (col_reg == '0);
            push_ctl.clamp = (col_reg == '0) ? (w_m1 == '0) : (col_reg == COL_W'(1));
            if (col_reg == w_m1)
            begin
                col_next = '0;
                if (row_reg == h_m1)
                begin
                    complete_next  = 1'b1;
                    prime_next     = (h_m1 == '0);
                    drain_col_next = '0;
                    wrapped_next   = 1'b0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        else if (is_drain || do_prime)
        begin
            push          = 1'b1;
            push_ctl.mode = (h_m1 == '0) ? VEC_DRAIN1 : VEC_DRAINN;
            if (!wrapped_reg)
            begin
                push_col       = drain_col_reg;
                push_ctl.emit  = is_drain;
                push_ctl.wrap  = (drain_col_reg == '0);
                push_ctl.clamp = (drain_col_reg == '0) ? (w_m1 == '0)
                                                       : (drain_col_reg == COL_W'(1));
                prime_next     = 1'b0;
                if (drain_col_reg == w_m1)
                begin
                    wrapped_next = 1'b1;
                end
                else
                begin
                    drain_col_next = drain_col_reg + 1'b1;
                end
            end
            else
            begin
                // last pixel of the frame; frame state clears
                push_col       = '0;
                push_ctl.emit  = 1'b1;
                push_ctl.wrap  = 1'b1;
                push_ctl.clamp = (w_m1 == '0);
                push_ctl.last  = 1'b1;
                col_next       = '0;
                row_next       = '0;
                complete_next  = 1'b0;
                drain_col_next = '0;
                wrapped_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            complete_reg  <= 1'b0;
            drain_col_reg <= '0;
            wrapped_reg   <= 1'b0;
            prime_reg     <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            complete_reg  <= complete_next;
            drain_col_reg <= drain_col_next;
            wrapped_reg   <= wrapped_next;
            prime_reg     <= prime_next;
        end
    end

    a_prime_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        prime_reg |-> (complete_reg && !wrapped_reg))
        else $error("prime outside drain phase");

    a_wrap_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |-> complete_reg)
        else $error("drain wrap outside drain phase");

    a_last_is_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_ctl.last) |=> !complete_reg)
        else $error("frame did not clear after last result");

endmodule

// ===== design/c3rb_back.sv =====
// ----------------------------------------------------------------------------
// c3rb_back: line store, window and multiply-accumulate pipeline
// Executes one column step per cycle while the result is not stalled: line-store read, window shift,
// 9-tap multiply per lane, two-level sum, output register.
// ----------------------------------------------------------------------------
module c3rb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = 10,
    parameter int LANES     = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    output logic                        pop,
    input  logic                        empty,
    input  c3rb_pkg::op_ctl_t           pop_ctl,
    input  logic [COL_W-1:0]            pop_col,
    input  logic [LANES*c3rb_pkg::SAMPLE_W-1:0] pop_pix,
    input  logic [c3rb_pkg::CHAN_W-1:0] chan_count,
    input  logic [c3rb_pkg::KSIZE-1:0][c3rb_pkg::COEF_GROUP_W-1:0] coef_groups,
    output logic                        result_valid,
    input  logic                        result_stall,
    output c3rb_pkg::result_item_t      result
);
    import c3rb_pkg::*;

    localparam int PIX_W  = LANES * SAMPLE_W;
    localparam int PROD_W = SAMPLE_W + COEF_W + 1;
    localparam int PART_W = PROD_W + 2;

    typedef logic [KSIZE-1:0][PIX_W-1:0] vec_t;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic adv;

    // stage 1: op plus line-store read
    logic               s1_valid_reg;
    op_ctl_t            s1_ctl_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [2*PIX_W-1:0] rd_reg;
    logic               fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic [2*PIX_W-1:0] rd_word;
    logic [PIX_W-1:0]   rd_prev, rd_older;
    logic               fwd_next;

    // window state and operand stage
    vec_t v0_reg, v1_reg;
    vec_t cur_vec, left_vec, right_vec;
    logic s2_valid_reg, s2_last_reg;
    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_reg;

    // products and partial sums
    logic s3_valid_reg, s3_last_reg;
    logic signed [PROD_W-1:0] prod_reg [LANES][KSIZE][KSIZE];
    logic s4_valid_reg, s4_last_reg;
    logic signed [PART_W-1:0] part_reg [LANES][KSIZE];

    logic signed [COEF_W-1:0] coef [KSIZE][KSIZE];
    logic signed [RESULT_W-1:0] lane_sum [NUM_CH];

    logic         result_valid_reg;
    result_item_t result_reg;

    assign adv          = !result_valid_reg || !result_stall;
    assign pop          = adv && !empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // coefficient (dy, dx): group dx, slice dy
    for (genvar dy = 0; dy < KSIZE; dy++)
    begin : g_cy
        for (genvar dx = 0; dx < KSIZE; dx++)
        begin : g_cx
            assign coef[dy][dx] = coef_groups[dx][dy*COEF_W +: COEF_W];
        end
    end

    // line store: word is {prev row, older row}
    assign fwd_next = s1_valid_reg && s1_ctl_reg.write && (s1_col_reg == pop_col);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s1_valid_reg && s1_ctl_reg.write)
            begin
                line_mem[s1_col_reg] <= {s1_pix_reg, rd_prev};
            end
            rd_reg       <= line_mem[pop_col];
            fwd_data_reg <= {s1_pix_reg, rd_prev};
        end
    end

    assign rd_word  = fwd_reg ? fwd_data_reg : rd_reg;
    assign rd_prev  = rd_word[2*PIX_W-1:PIX_W];
    assign rd_older = rd_word[PIX_W-1:0];

    always_comb
    begin
        case (s1_ctl_reg.mode)
            VEC_ROW0:   cur_vec = {s1_pix_reg, s1_pix_reg, s1_pix_reg};
            VEC_ROW1:   cur_vec = {s1_pix_reg, rd_prev, rd_prev};
            VEC_ROWN:   cur_vec = {s1_pix_reg, rd_prev, rd_older};
            VEC_DRAIN1: cur_vec = {rd_prev, rd_prev, rd_prev};
            VEC_DRAINN: cur_vec = {rd_prev, rd_prev, rd_older};
            default:    cur_vec = {s1_pix_reg, rd_prev, rd_older};
        endcase
        left_vec  = s1_ctl_reg.clamp ? v0_reg : v1_reg;
        right_vec = s1_ctl_reg.wrap  ? v0_reg : cur_vec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg     <= !empty;
            fwd_reg          <= fwd_next;
            s2_valid_reg     <= s1_valid_reg && s1_ctl_reg.emit;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            result_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg  <= pop_ctl;
            s1_col_reg  <= pop_col;
            s1_pix_reg  <= pop_pix;
            s2_last_reg <= s1_ctl_reg.last;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;
            if (s1_valid_reg)
            begin
                v1_reg <= v0_reg;
                v0_reg <= cur_vec;
            end
            for (int dy = 0; dy < KSIZE; dy++)
            begin
                win_reg[dy][0] <= left_vec[dy];
                win_reg[dy][1] <= v0_reg[dy];
                win_reg[dy][2] <= right_vec[dy];
            end
            for (int l = 0; l < LANES; l++)
            begin
                for (int dy = 0; dy < KSIZE; dy++)
                begin
                    for (int dx = 0; dx < KSIZE; dx++)
                    begin
                        prod_reg[l][dy][dx] <=
                            PROD_W'($signed({1'b0, win_reg[dy][dx][l*SAMPLE_W +: SAMPLE_W]}))
                            * PROD_W'(coef[dy][dx]);
                    end
                    part_reg[l][dy] <= PART_W'(prod_reg[l][dy][0])
                                     + PART_W'(prod_reg[l][dy][1])
                                     + PART_W'(prod_reg[l][dy][2]);
                end
            end
            result_reg.result_c0  <= lane_sum[0];
            result_reg.result_c1  <= lane_sum[1];
            result_reg.result_c2  <= lane_sum[2];
            result_reg.result_c3  <= lane_sum[3];
            result_reg.frame_last <= s4_last_reg;
        end
    end

    for (genvar l = 0; l < NUM_CH; l++)
    begin : g_sum
        if (l < LANES)
        begin : g_on
            assign lane_sum[l] = (CHAN_W'(l) < chan_count)
                               ? RESULT_W'(part_reg[l][0]) + RESULT_W'(part_reg[l][1])
                                 + RESULT_W'(part_reg[l][2])
                               : '0;
        end
        else
        begin : g_off
            assign lane_sum[l] = '0;
        end
    end

    a_fwd_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_reg) |-> $past(s1_valid_reg && s1_ctl_reg.write))
        else $error("line store bypass without a write");

    a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_last) |-> $past(s4_valid_reg) || $stable(result))
        else $error("flagged result without pipeline data");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> (pop == 1'b0))
        else $error("queue popped while output blocked");

endmodule

// ===== design/conv3x3_replicate_border.sv =====
// ----------------------------------------------------------------------------
// conv3x3_replicate_border: streaming 3x3 convolution, replicate padding
// Raster-order pixels of up to four 8-bit lanes are convolved with one
// signed Q8.8 3x3 kernel; border neighbors copy the nearest edge pixel.
//
//   channel   signals                          transaction
//   -------   -------------------------------  -------------------------------
//   pixel     pixel_valid / pixel_stall/pixel  pixel (action 0) or drain (1)
//   result    result_valid/result_stall/result four raw lane sums + frame_last
//   config    cfg_we / cfg_index / cfg_data    one register write, no wait
//
// One transaction per clock in steady state, when no stall holds it. A result
// passes the queue, line-store read, window, multiply and partial-sum registers,
// then the lane sum into the output register; one line-store read and one write
// per column step set the one-per-clock rate. A single-row frame pushes one
// extra op to load the window before drain.
// Reset clears control and restores register defaults; line store is not
// cleared (only rows written in the current frame are read).
// A stalled result freezes the back end; the op queue keeps the pixel side
// running until it fills.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border #(
    parameter int MAX_WIDTH  = c3rb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3rb_pkg::DEF_MAX_HEIGHT,
    parameter int LANES      = c3rb_pkg::DEF_LANES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  c3rb_pkg::pixel_item_t           pixel,
    output logic                            result_valid,
    input  logic                            result_stall,
    output c3rb_pkg::result_item_t          result,
    input  logic                            cfg_we,
    input  logic [c3rb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [c3rb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import c3rb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PIX_W = LANES * SAMPLE_W;

    // configuration registers
    logic [GEOM_W-1:0]                    width_reg;
    logic [GEOM_W-1:0]                    height_reg;
    logic [CHAN_W-1:0]                    chan_reg;
    logic [KSIZE-1:0][COEF_GROUP_W-1:0]   coef_reg;
    logic                                 restart;

    // effective (clamped) geometry and lane count
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic [CHAN_W-1:0] chan_count;

    // front to queue
    logic             push, full;
    op_ctl_t          push_ctl;
    logic [COL_W-1:0] push_col;
    logic [PIX_W-1:0] push_pix;

    // queue to back
    logic             pop, empty;
    op_ctl_t          pop_ctl;
    logic [COL_W-1:0] pop_col;
    logic [PIX_W-1:0] pop_pix;

    // width/height writes restart the frame
    assign restart = cfg_we && ((cfg_index == CFG_FRAME_WIDTH) ||
                                (cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_FRAME_WIDTH;
            height_reg  <= RST_FRAME_HEIGHT;
            chan_reg    <= RST_CHANNELS;
            coef_reg[0] <= RST_COEF_SIDE;
            coef_reg[1] <= RST_COEF_CENTER;
            coef_reg[2] <= RST_COEF_SIDE;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg   <= cfg_data[GEOM_W-1:0];
                CFG_FRAME_HEIGHT: height_reg  <= cfg_data[GEOM_W-1:0];
                CFG_CHANNELS:     chan_reg    <= cfg_data[CHAN_W-1:0];
                CFG_COEF_LEFT:    coef_reg[0] <= cfg_data[COEF_GROUP_W-1:0];
                CFG_COEF_CENTER:  coef_reg[1] <= cfg_data[COEF_GROUP_W-1:0];
                CFG_COEF_RIGHT:   coef_reg[2] <= cfg_data[COEF_GROUP_W-1:0];
                default:          ;  // unknown index: dropped
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_m1 = '0;
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_m1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = COL_W'(width_reg - 1'b1);
        end

        if (height_reg == '0)
        begin
            h_m1 = '0;
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_m1 = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_m1 = ROW_W'(height_reg - 1'b1);
        end

        if (chan_reg == '0)
        begin
            chan_count = CHAN_W'(1);
        end
        else if (int'(chan_reg) > LANES)
        begin
            chan_count = CHAN_W'(LANES);
        end
        else
        begin
            chan_count = chan_reg;
        end
    end

    c3rb_front #(
        .COL_W (COL_W),
        .ROW_W (ROW_W),
        .LANES (LANES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .restart     (restart),
        .w_m1        (w_m1),
        .h_m1        (h_m1),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_col    (push_col),
        .push_pix    (push_pix),
        .full        (full)
    );

    c3rb_fifo #(
        .COL_W (COL_W),
        .PIX_W (PIX_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ctl (push_ctl),
        .push_col (push_col),
        .push_pix (push_pix),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .pop_ctl  (pop_ctl),
        .pop_col  (pop_col),
        .pop_pix  (pop_pix)
    );

    c3rb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .LANES     (LANES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .empty        (empty),
        .pop_ctl      (pop_ctl),
        .pop_col      (pop_col),
        .pop_pix      (pop_pix),
        .chan_count   (chan_count),
        .coef_groups  (coef_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
